FILE: rtl/spectral_centroid_unit_defines.svh
// assertion helpers for the spectral centroid unit
// both expect clk and rst_n in scope
`ifndef SPECTRAL_CENTROID_UNIT_DEFINES_SVH
`define SPECTRAL_CENTROID_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define SPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spcent_pkg.sv
package spcent_pkg;

  localparam int MAG_W        = 16;
  localparam int SR_W         = 18;
  localparam int CENT_W       = 25;
  localparam int FRAC_W       = 8;
  localparam int MAX_BINS_DEF = 4096;
  localparam int MAG_BITS_DEF = 16;

  localparam logic [SR_W-1:0] SR_RESET = SR_W'(44100);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } in_t;

  typedef struct packed {
    logic [CENT_W-1:0] centroid_hz;
    logic              zero_energy;
  } out_t;

endpackage

FILE: rtl/spectral_centroid_unit.sv
// Spectral centroid of a stream of FFT magnitude bins.
// Input channel (in_valid/in_stall/in_data): one bin per beat, in bin order, last_bin
// set on the final bin of a frame. A frame that reaches MAX_BINS bins ends there.
// Output channel (out_valid/out_stall/out_data): one beat per frame carrying the
// centroid in Hz (unsigned, 8 fraction bits, truncated) and a zero-energy flag.
// Config channel (cfg_valid/cfg_ready/cfg_data): sample rate in Hz, always ready.
// Throughput: bins that do not end a frame are taken one per cycle. The final bin
// starts a shared add/subtract unit that runs N*S (MPL_W steps), sample_rate*W
// (MPL_W steps) and a restoring divide (25 steps); MPL_W is the larger of 18 and
// the bin counter width. in_stall is high from the final bin until the result is
// loaded into the output register. A zero-energy frame skips the unit and goes
// from its final bin straight to the output state.
// The result sits in an output register; while it waits on out_stall the block
// keeps taking bins of the next frame and only holds at that frame's end.
// Reset (rst_n, synchronous) clears the accumulators and sets 44100 Hz.
`include "spectral_centroid_unit_defines.svh"

module spectral_centroid_unit #(
  parameter int MAX_BINS = spcent_pkg::MAX_BINS_DEF,
  parameter int MAG_BITS = spcent_pkg::MAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spcent_pkg::in_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output spcent_pkg::out_t            out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spcent_pkg::SR_W-1:0] cfg_data
);
  import spcent_pkg::*;

  localparam int CNT_W   = $clog2(MAX_BINS + 1);
  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int S_W     = MAG_W + IDX_W;
  localparam int W_W     = MAG_W + 2 * IDX_W;
  localparam int PROD_W  = CNT_W + MAG_W;
  localparam int MAG_USE = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam logic [MAG_W-1:0] MAG_MASK = MAG_W'((17'd1 << MAG_USE) - 17'd1);
  localparam int NUM_W   = SR_W + W_W;
  localparam int DVD_W   = NUM_W + FRAC_W;
  localparam int DEN_W   = 1 + CNT_W + S_W;
  localparam int REM_W   = DEN_W + 1;
  localparam int U_W     = (NUM_W > REM_W) ? NUM_W : REM_W;
  localparam int MPL_W   = (CNT_W > SR_W) ? CNT_W : SR_W;
  localparam int STEP_N  = (MPL_W > CENT_W) ? MPL_W : CENT_W;
  localparam int STEP_W  = $clog2(STEP_N);

  typedef enum logic [4:0] {
    S_ACC   = 5'b00001,
    S_MUL_D = 5'b00010,
    S_MUL_N = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t             st_r, st_nxt;
  logic [SR_W-1:0]    sr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W_W-1:0]     w_r, w_nxt;
  logic [S_W-1:0]     s_r, s_nxt;
  logic [U_W-1:0]     acc_r, acc_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic [MPL_W-1:0]   mplr_r, mplr_nxt;
  logic [CENT_W-1:0]  qd_r, qd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               out_load;

  logic               in_acc;
  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   cnt_inc;
  logic [S_W-1:0]     s_inc;
  logic [REM_W-1:0]   rem_shift;
  logic [DVD_W-1:0]   num_full;

  logic [U_W-1:0]     unit_a, unit_b;
  logic               unit_sub;
  logic [U_W:0]       unit_sum;

  assign in_stall  = (st_r != S_ACC);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_acc  = in_valid && !in_stall;
  assign mag     = in_data.magnitude & MAG_MASK;
  assign prod    = PROD_W'(cnt_r) * PROD_W'(mag);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign s_inc   = s_r + S_W'(mag);

  assign rem_shift = {acc_r[DEN_W-1:0], qd_r[CENT_W-1]};
  assign num_full  = {unit_sum[NUM_W-1:0], {FRAC_W{1'b0}}};

  // shared add/subtract unit, carry out is the no-borrow flag when subtracting
  assign unit_sum = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                  + (U_W + 1)'(unit_sub);

  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    case (st_r)
      S_MUL_D: begin
        unit_a = acc_r << 1;
        unit_b = mplr_r[MPL_W-1] ? U_W'(s_r) : '0;
      end
      S_MUL_N: begin
        unit_a = acc_r << 1;
        unit_b = mplr_r[MPL_W-1] ? U_W'(w_r) : '0;
      end
      S_DIV: begin
        unit_a   = U_W'(rem_shift);
        unit_b   = U_W'(den_r);
        unit_sub = 1'b1;
      end
      default: begin
        unit_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    den_nxt       = den_r;
    mplr_nxt      = mplr_r;
    qd_nxt        = qd_r;
    step_nxt      = step_r;
    zero_nxt      = zero_r;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (st_r)
      S_ACC: begin
        if (in_acc) begin
          cnt_nxt = cnt_inc;
          w_nxt   = w_r + W_W'(prod);
          s_nxt   = s_inc;
          if (in_data.last_bin || cnt_inc == CNT_W'(MAX_BINS)) begin
            zero_nxt = (s_inc == '0);
            if (s_inc == '0) begin
              st_nxt = S_OUT;
            end else begin
              acc_nxt  = '0;
              mplr_nxt = MPL_W'(cnt_inc);
              step_nxt = STEP_W'(MPL_W - 1);
              st_nxt   = S_MUL_D;
            end
          end
        end
      end
      S_MUL_D: begin
        acc_nxt  = unit_sum[U_W-1:0];
        mplr_nxt = mplr_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          // denominator is 2*N*S
          den_nxt  = {unit_sum[DEN_W-2:0], 1'b0};
          acc_nxt  = '0;
          mplr_nxt = MPL_W'(sr_r);
          step_nxt = STEP_W'(MPL_W - 1);
          st_nxt   = S_MUL_N;
        end
      end
      S_MUL_N: begin
        acc_nxt  = unit_sum[U_W-1:0];
        mplr_nxt = mplr_r << 1;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          // quotient fits CENT_W bits, so the top part is already below the divisor
          acc_nxt  = U_W'(num_full[DVD_W-1:CENT_W]);
          qd_nxt   = num_full[CENT_W-1:0];
          step_nxt = STEP_W'(CENT_W - 1);
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        acc_nxt  = unit_sum[U_W] ? unit_sum[U_W-1:0] : U_W'(rem_shift);
        qd_nxt   = {qd_r[CENT_W-2:0], unit_sum[U_W]};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load                 = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.centroid_hz = zero_r ? '0 : qd_r;
          out_data_nxt.zero_energy = zero_r;
          cnt_nxt                  = '0;
          w_nxt                    = '0;
          s_nxt                    = '0;
          st_nxt                   = S_ACC;
        end
      end
      default: begin
        st_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_ACC;
      sr_r        <= SR_RESET;
      cnt_r       <= '0;
      w_r         <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      w_r         <= w_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        sr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    den_r  <= den_nxt;
    mplr_r <= mplr_nxt;
    qd_r   <= qd_nxt;
    step_r <= step_nxt;
    zero_r <= zero_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  `SPC_ASSERT_SAME(a_rem_below_den, st_r == S_DIV, acc_r < U_W'(den_r),
                   "remainder not below divisor")
  `SPC_ASSERT_SAME(a_zero_centroid, out_valid_r && out_data_r.zero_energy,
                   out_data_r.centroid_hz == '0, "zero energy with nonzero centroid")
  `SPC_ASSERT_NEXT(a_final_holds, in_valid && !in_stall && in_data.last_bin, in_stall,
                   "input not held after final bin")
  `SPC_ASSERT_SAME(a_cnt_bound, st_r == S_ACC, cnt_r < CNT_W'(MAX_BINS),
                   "bin counter past frame limit")

endmodule
